[hw/rtl/matrix_inverse_4x4_assert.svh]
// assertion helpers shared by the checker
`ifndef MATRIX_INVERSE_4X4_ASSERT_SVH
`define MATRIX_INVERSE_4X4_ASSERT_SVH

// same-cycle implication
`define MI4_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix_inverse_4x4 check failed");

// next-cycle implication
`define MI4_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix_inverse_4x4 check failed");

`endif

[hw/rtl/mi4_pkg.sv]
package mi4_pkg;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_MUL1,
    ST_M2S,
    ST_MUL2,
    ST_ACC,
    ST_COF,
    ST_DRD,
    ST_DST,
    ST_DMUL,
    ST_DACC,
    ST_ORD,
    ST_OST,
    ST_ODIV,
    ST_OUT
  } mi4_state_t;

  typedef enum logic [1:0] {
    MS_TERM1,
    MS_TERM2,
    MS_DET
  } mi4_msel_t;

  typedef struct packed {
    logic       elem_we;
    logic [3:0] elem_addr;
    logic       cap_a;
    logic       cap_c;
    logic       mul_start;
    mi4_msel_t  mul_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       term_neg;
    logic       cof_we;
    logic       cof_odd;
    logic [3:0] cof_addr;
    logic       det_clr;
    logic       det_add;
    logic       div_start;
    logic       out_load;
  } mi4_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic det_zero;
  } mi4_stat_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_neg64(input logic signed [63:0] a);
    logic signed [63:0] s;
    s = (a == S64_MIN) ? S64_MAX : -a;
    return s;
  endfunction

  // element index for one factor of one product term of the 3x3 minor (r, c)
  function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                            input logic [2:0] term, input logic [1:0] slot);
    logic [1:0] mi;
    logic [1:0] mj;
    logic [1:0] row;
    logic [1:0] col;
    case ({term, slot})
      5'b000_00: begin mi = 2'd0; mj = 2'd0; end
      5'b000_01: begin mi = 2'd1; mj = 2'd1; end
      5'b000_10: begin mi = 2'd2; mj = 2'd2; end
      5'b001_00: begin mi = 2'd0; mj = 2'd1; end
      5'b001_01: begin mi = 2'd1; mj = 2'd2; end
      5'b001_10: begin mi = 2'd2; mj = 2'd0; end
      5'b010_00: begin mi = 2'd0; mj = 2'd2; end
      5'b010_01: begin mi = 2'd1; mj = 2'd0; end
      5'b010_10: begin mi = 2'd2; mj = 2'd1; end
      5'b011_00: begin mi = 2'd2; mj = 2'd0; end
      5'b011_01: begin mi = 2'd1; mj = 2'd1; end
      5'b011_10: begin mi = 2'd0; mj = 2'd2; end
      5'b100_00: begin mi = 2'd2; mj = 2'd1; end
      5'b100_01: begin mi = 2'd1; mj = 2'd2; end
      5'b100_10: begin mi = 2'd0; mj = 2'd0; end
      5'b101_00: begin mi = 2'd2; mj = 2'd2; end
      5'b101_01: begin mi = 2'd1; mj = 2'd0; end
      5'b101_10: begin mi = 2'd0; mj = 2'd1; end
      default:   begin mi = 2'd0; mj = 2'd0; end
    endcase
    row = (mi >= r) ? mi + 2'd1 : mi;
    col = (mj >= c) ? mj + 2'd1 : mj;
    return {row, col};
  endfunction

endpackage

[hw/rtl/mi4_ram.sv]
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mi4_mul.sv]
module mi4_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] x,
  input  logic signed [63:0] y,
  output logic               done,
  output logic signed [63:0] p
);

  logic         busy_r;
  logic [2:0]   step_r;
  logic [63:0]  mx_r;
  logic [63:0]  my_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic         done_r;
  logic signed [63:0] p_r;

  logic [31:0]  xa;
  logic [31:0]  yb;
  logic [63:0]  pp;
  logic [127:0] ppw;
  logic [127:0] q;
  logic [127:0] limit;
  logic [127:0] qs;

  assign xa = step_r[1] ? mx_r[63:32] : mx_r[31:0];
  assign yb = step_r[0] ? my_r[63:32] : my_r[31:0];
  assign pp = 64'(xa) * 64'(yb);

  always_comb begin
    ppw = 128'(pp);
    if (step_r[0] ^ step_r[1]) begin
      ppw = 128'(pp) << 32;
    end else if (step_r[1]) begin
      ppw = 128'(pp) << 64;
    end
    q     = acc_r >> FRAC_BITS;
    limit = neg_r ? (128'(1) << 63) : ((128'(1) << 63) - 128'(1));
    qs    = (q > limit) ? limit : q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx_r  <= x[63] ? 64'(-x) : 64'(x);
      my_r  <= y[63] ? 64'(-y) : 64'(y);
      neg_r <= x[63] ^ y[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r == 3'd4) begin
        p_r <= neg_r ? -$signed(qs[63:0]) : $signed(qs[63:0]);
      end else begin
        acc_r <= acc_r + ppw;
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

[hw/rtl/mi4_div.sv]
module mi4_div #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [63:0]    num,
  input  logic signed [63:0]    den,
  output logic                  done,
  output logic [ELEM_WIDTH-1:0] q
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] q_r;
  logic [64:0]   rem_r;
  logic [63:0]   d_r;
  logic          neg_r;
  logic [ELEM_WIDTH-1:0] res_r;

  logic [64:0]   rem_sh;
  logic          qbit;
  logic [64:0]   rem_new;
  logic [NW-1:0] limit;
  logic [NW-1:0] qs;

  always_comb begin
    rem_sh  = {rem_r[63:0], num_r[NW-1]};
    qbit    = (rem_sh >= {1'b0, d_r});
    rem_new = qbit ? rem_sh - {1'b0, d_r} : rem_sh;
    limit   = neg_r ? (NW'(1) << (ELEM_WIDTH - 1))
                    : ((NW'(1) << (ELEM_WIDTH - 1)) - NW'(1));
    qs      = (q_r > limit) ? limit : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= NW'(num[63] ? 64'(-num) : 64'(num)) << FRAC_BITS;
      d_r   <= den[63] ? 64'(-den) : 64'(den);
      neg_r <= num[63] ^ den[63];
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        res_r <= neg_r ? ELEM_WIDTH'(-qs) : ELEM_WIDTH'(qs);
      end else begin
        num_r <= num_r << 1;
        rem_r <= rem_new;
        q_r   <= {q_r[NW-2:0], qbit};
      end
    end
  end

  assign done = done_r;
  assign q    = res_r;

endmodule

[hw/rtl/mi4_ctrl.sv]
module mi4_ctrl
  import mi4_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic      out_tlast,
  output mi4_cmd_t  cmd,
  input  mi4_stat_t stat
);

  mi4_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [2:0] term_r, term_nxt;
  logic [3:0] k_r, k_nxt;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_tvalid && (state_r == ST_LOAD);
  assign out_acc = out_tready && (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_acc && cnt_r == 4'd15) state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_RDC;
      ST_RDC:  state_nxt = ST_MUL1;
      ST_MUL1: if (stat.mul_done) state_nxt = ST_M2S;
      ST_M2S:  state_nxt = ST_MUL2;
      ST_MUL2: if (stat.mul_done) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (term_r == 3'd5) ? ST_COF : ST_RDA;
      ST_COF: begin
        if (idx_r[3:2] == 2'd0) begin
          state_nxt = ST_DRD;
        end else if (idx_r == 4'd15) begin
          state_nxt = ST_ORD;
        end else begin
          state_nxt = ST_RDA;
        end
      end
      ST_DRD:  state_nxt = ST_DST;
      ST_DST:  state_nxt = ST_DMUL;
      ST_DMUL: if (stat.mul_done) state_nxt = ST_DACC;
      ST_DACC: state_nxt = ST_RDA;
      ST_ORD:  state_nxt = ST_OST;
      ST_OST:  state_nxt = stat.det_zero ? ST_OUT : ST_ODIV;
      ST_ODIV: if (stat.div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_acc) state_nxt = (k_r == 4'd15) ? ST_LOAD : ST_ORD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    term_nxt = term_r;
    k_nxt    = k_r;
    case (state_r)
      ST_LOAD: begin
        idx_nxt  = '0;
        term_nxt = '0;
        k_nxt    = '0;
        if (in_acc) cnt_nxt = cnt_r + 4'd1;
      end
      ST_ACC:  term_nxt = (term_r == 3'd5) ? 3'd0 : term_r + 3'd1;
      ST_COF:  if (idx_r[3:2] != 2'd0) idx_nxt = idx_r + 4'd1;
      ST_DACC: idx_nxt = idx_r + 4'd1;
      ST_OUT:  if (out_acc) k_nxt = k_r + 4'd1;
      default: ;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MS_TERM1;
    cmd.elem_addr = minor_addr(idx_r[3:2], idx_r[1:0], term_r, 2'd2);
    cmd.cof_addr  = {k_r[1:0], k_r[3:2]};
    cmd.term_neg  = (term_r >= 3'd3);
    cmd.cof_odd   = idx_r[2] ^ idx_r[0];
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    out_tlast     = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready     = 1'b1;
        cmd.elem_addr = cnt_r;
        cmd.elem_we   = in_acc;
        cmd.acc_clr   = 1'b1;
        cmd.det_clr   = 1'b1;
      end
      ST_RDA: cmd.elem_addr = minor_addr(idx_r[3:2], idx_r[1:0], term_r, 2'd0);
      ST_RDB: begin
        cmd.elem_addr = minor_addr(idx_r[3:2], idx_r[1:0], term_r, 2'd1);
        cmd.cap_a     = 1'b1;
      end
      ST_RDC: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_TERM1;
      end
      ST_MUL1: cmd.cap_c = 1'b1;
      ST_M2S: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_TERM2;
      end
      ST_ACC: cmd.acc_add = 1'b1;
      ST_COF: begin
        cmd.cof_we   = 1'b1;
        cmd.cof_addr = idx_r;
        cmd.acc_clr  = 1'b1;
      end
      ST_DRD: cmd.elem_addr = {2'b00, idx_r[1:0]};
      ST_DST: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_DET;
      end
      ST_DACC: cmd.det_add = 1'b1;
      ST_OST: begin
        cmd.div_start = !stat.det_zero;
        cmd.out_load  = stat.det_zero;
      end
      ST_ODIV: cmd.out_load = stat.div_done;
      ST_OUT: begin
        out_tvalid = 1'b1;
        out_tlast  = (k_r == 4'd15);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
      term_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      term_r  <= term_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

[hw/rtl/mi4_dp.sv]
module mi4_dp
  import mi4_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ELEM_WIDTH-1:0] in_element,
  output logic [ELEM_WIDTH-1:0] out_element,
  output logic                  out_singular,
  input  mi4_cmd_t              cmd,
  output mi4_stat_t             stat
);

  logic [ELEM_WIDTH-1:0] elem_rd;
  logic signed [63:0]    elem_ext;
  logic [63:0]           cof_rd;
  logic signed [63:0]    a_r;
  logic signed [63:0]    c_r;
  logic signed [63:0]    acc_r;
  logic signed [63:0]    det_r;
  logic signed [63:0]    cof_r;
  logic signed [63:0]    cofv;
  logic signed [63:0]    mx;
  logic signed [63:0]    my;
  logic signed [63:0]    mp;
  logic                  mdone;
  logic                  ddone;
  logic [ELEM_WIDTH-1:0] dq;
  logic [ELEM_WIDTH-1:0] out_r;
  logic                  sing_r;

  assign elem_ext = 64'($signed(elem_rd));
  assign cofv     = cmd.cof_odd ? sat_neg64(acc_r) : acc_r;

  mi4_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(16)) u_elem_ram (
    .clk   (clk),
    .we    (cmd.elem_we),
    .waddr (cmd.elem_addr),
    .wdata (in_element),
    .raddr (cmd.elem_addr),
    .rdata (elem_rd)
  );

  mi4_ram #(.WIDTH(64), .DEPTH(16)) u_cof_ram (
    .clk   (clk),
    .we    (cmd.cof_we),
    .waddr (cmd.cof_addr),
    .wdata (cofv),
    .raddr (cmd.cof_addr),
    .rdata (cof_rd)
  );

  always_comb begin
    case (cmd.mul_sel)
      MS_TERM1: begin mx = a_r;      my = elem_ext; end
      MS_TERM2: begin mx = mp;       my = c_r;      end
      MS_DET:   begin mx = elem_ext; my = cof_r;    end
      default:  begin mx = a_r;      my = elem_ext; end
    endcase
  end

  mi4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .done  (mdone),
    .p     (mp)
  );

  mi4_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ($signed(cof_rd)),
    .den   (det_r),
    .done  (ddone),
    .q     (dq)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_a) a_r <= elem_ext;
    if (cmd.cap_c) c_r <= elem_ext;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= sat_add64(acc_r, cmd.term_neg ? sat_neg64(mp) : mp);
    end
    if (cmd.cof_we) cof_r <= cofv;
    if (cmd.det_clr) begin
      det_r <= '0;
    end else if (cmd.det_add) begin
      det_r <= sat_add64(det_r, mp);
    end
    if (cmd.out_load) begin
      out_r  <= stat.det_zero ? '0 : dq;
      sing_r <= stat.det_zero;
    end
  end

  assign stat.mul_done = mdone;
  assign stat.div_done = ddone;
  assign stat.det_zero = (det_r == '0);

  assign out_element  = out_r;
  assign out_singular = sing_r;

endmodule

[hw/rtl/matrix_inverse_4x4.sv]
// 4x4 matrix inverse by the adjugate in signed fixed point (ELEM_WIDTH bits,
// FRAC_BITS fraction bits). Send sixteen elements in row-major order, one per
// accepted request; in_tready is high only while a matrix is being loaded.
// The block then forms the sixteen cofactors and the determinant with one
// iterative 64x64 fixed multiplier (four 32x32 partial products plus a
// saturation step, two products per minor term), and divides each adjugate
// entry by the determinant with a one-bit-per-cycle divider of 64+FRAC_BITS
// steps. Results come out in row-major order with out_tlast on the sixteenth;
// a zero determinant gives zero results with the singular flag set and skips
// the divider.
module matrix_inverse_4x4
  import mi4_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((ELEM_WIDTH+7)/8)*8-1:0]   in_tdata,   // element
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((ELEM_WIDTH+7)/8)*8-1:0]   out_tdata,  // inverse_element
  output logic [0:0]                        out_tuser,  // singular
  output logic                              out_tlast
);

  localparam int DW = ((ELEM_WIDTH + 7) / 8) * 8;

  mi4_cmd_t              cmd;
  mi4_stat_t             stat;
  logic [ELEM_WIDTH-1:0] out_elem;
  logic                  out_sing;

  mi4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  mi4_dp #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_element   (in_tdata[ELEM_WIDTH-1:0]),
    .out_element  (out_elem),
    .out_singular (out_sing),
    .cmd          (cmd),
    .stat         (stat)
  );

  assign out_tdata    = DW'(out_elem);
  assign out_tuser[0] = out_sing;

endmodule

[hw/rtl/mi4_checker.sv]
`include "matrix_inverse_4x4_assert.svh"

module mi4_checker #(
  parameter int ELEM_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [((ELEM_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  `MI4_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `MI4_ASSERT_IMP(a_singular_zero, out_tvalid && out_tuser[0], out_tdata == '0)
  `MI4_ASSERT_IMP(a_no_overlap, in_tready, !out_tvalid)
  `MI4_ASSERT_NXT(a_last_ends, out_tvalid && out_tready && out_tlast, !out_tvalid && in_tready)

endmodule

bind matrix_inverse_4x4 mi4_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi4_checker (.*);
